// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator RTL.
// Included by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFAS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("check failed");
`define FFAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define FFAS_ASSERT(lbl, cond)
`define FFAS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== rtl/ffas_pkg.sv =====
// Types and constants of the first-fit aligned segment allocator.
// No dependencies.
`default_nettype none
package ffas_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AlignW = 17;
  localparam logic [DataW-1:0] BufSizeReset = 32'd65536;
  localparam logic [1:0] AddrBufferSize = 2'd0;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoSpace = 2'd1;
  localparam logic [1:0] StatTooBig  = 2'd2;
  localparam logic [1:0] StatFull    = 2'd3;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DataW-1:0]  request_start;
    logic [DataW-1:0]  request_size;
    logic [AlignW-1:0] alignment;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DataW-1:0] granted_start;
    logic [DataW-1:0] granted_size;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_READ_I, OP_FREE_CHK, OP_SKIP, OP_DIV_START,
    OP_ALIGN, OP_FIT, OP_NEWLEN, OP_HIT_WR, OP_FREE_DEC, OP_FREE_NEXT,
    OP_READ_LAST, OP_MOVE, OP_APPEND, OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_RD, ST_EVAL, ST_DIV, ST_ALIGN, ST_FIT, ST_NEWLEN,
    ST_HIT_WR, ST_F_DEC, ST_F_NEXT, ST_RM_RD, ST_RM_WR, ST_APPEND, ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic init_pend;
    logic mode;
    logic count_zero;
    logic too_big;
    logic scan_end;
    logic len_lt_align;
    logic div_done;
    logic fit;
    logic newlen_zero;
    logic gap_zero;
    logic full;
    logic prev_v;
    logic next_v;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ffas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffas_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ffas_mod.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo 17-bit divisor, one bit a cycle.
// Depends on ffas_pkg.
`default_nettype none
module ffas_mod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ffas_pkg::DataW-1:0]    dividend_i,
  input  wire logic [ffas_pkg::AlignW-1:0]   divisor_i,
  output logic                               done_o,
  output logic      [ffas_pkg::AlignW-1:0]   rem_o
);
  import ffas_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic                busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DataW-1:0]    dvd_q, dvd_d;
  logic [AlignW-1:0]   div_q, div_d, rem_q, rem_d;
  logic [AlignW:0]     trial, diff;

  // one restoring step
  always_comb begin
    trial  = {rem_q, dvd_q[DataW-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? diff[AlignW-1:0] : trial[AlignW-1:0];
      dvd_d = {dvd_q[DataW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/ffas_dp.sv =====
// Datapath: segment table RAM, scan registers, remainder unit, result register.
// Depends on ffas_pkg, ffas_ram, ffas_mod and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ffas_dp #(
  parameter int unsigned MaxSegments = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ffas_pkg::dp_cmd_t          cmd_i,
  output ffas_pkg::dp_stat_t              stat_o,
  input  wire ffas_pkg::req_t             in_req_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [ffas_pkg::DataW-1:0] cfg_wdata_i,
  output logic      [ffas_pkg::DataW-1:0] buf_size_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ffas_pkg::rsp_t                  out_rsp_o
);
  import ffas_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);

  logic [DataW-1:0]  buf_q;
  logic              init_q, ov_q;
  logic [CntW-1:0]   cnt_q, idx_q, cnt_m1;
  req_t              req_q;
  logic [AlignW-1:0] al_q, gap_q;
  logic              prev_v_q, next_v_q;
  logic [IdxW-1:0]   prev_idx_q, next_idx_q, hit_q, rm_idx_q;
  logic [DataW-1:0]  prev_s_q, prev_l_q, next_l_q, newlen_q, app_s_q, app_l_q;
  logic [DataW:0]    aligned_q, end_q;
  rsp_t              rsp_q;

  logic                  rd_en, wr_en;
  logic [IdxW-1:0]       rd_addr, wr_addr;
  logic [2*DataW-1:0]    wr_data, rd_data;
  logic [DataW-1:0]      seg_s, seg_l;
  logic                  div_done;
  logic [AlignW-1:0]     rem;
  logic [DataW:0]        seg_end, req_end;
  logic                  hit_prev, hit_next;

  assign seg_s   = rd_data[2*DataW-1:DataW];
  assign seg_l   = rd_data[DataW-1:0];
  assign cnt_m1  = cnt_q - 1'b1;
  assign seg_end = {1'b0, seg_s} + {1'b0, seg_l};
  assign req_end = {1'b0, req_q.request_start} + {1'b0, req_q.request_size};
  assign hit_next = (req_end == {1'b0, seg_s});
  assign hit_prev = (seg_end == {1'b0, req_q.request_start});

  // table port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {{DataW{1'b0}}, buf_q};
    unique case (cmd_i.op)
      OP_INIT: wr_en = 1'b1;
      OP_READ_I: rd_en = 1'b1;
      OP_READ_LAST: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[IdxW-1:0];
      end
      OP_HIT_WR: begin
        wr_en   = 1'b1;
        wr_addr = hit_q;
        wr_data = {aligned_q[DataW-1:0] + req_q.request_size, newlen_q};
      end
      OP_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = rm_idx_q;
        wr_data = rd_data;
      end
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[IdxW-1:0];
        wr_data = {app_s_q, app_l_q};
      end
      default: ;
    endcase
  end

  ffas_ram #(.Width(2 * DataW), .Depth(MaxSegments)) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  ffas_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.op == OP_DIV_START),
    .dividend_i(seg_s),
    .divisor_i (al_q),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= BufSizeReset;
      init_q   <= 1'b1;
      cnt_q    <= CntW'(1);
      idx_q    <= '0;
      prev_v_q <= 1'b0;
      next_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        buf_q <= cfg_wdata_i;
      end
      // table init pending: a write wins over an init in the same cycle
      if (cfg_we_i) begin
        init_q <= 1'b1;
      end else if (cmd_i.op == OP_INIT) begin
        init_q <= 1'b0;
      end
      // output slot: loaded by a new response, emptied when taken
      if (cmd_i.op == OP_RESULT) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_INIT: cnt_q <= CntW'(1);
        OP_LOAD: begin
          idx_q    <= '0;
          prev_v_q <= 1'b0;
          next_v_q <= 1'b0;
        end
        OP_FREE_CHK: begin
          idx_q <= idx_q + 1'b1;
          if (hit_prev) prev_v_q <= 1'b1;
          if (hit_next) next_v_q <= 1'b1;
        end
        OP_SKIP: idx_q <= idx_q + 1'b1;
        OP_FREE_DEC: begin
          prev_v_q <= 1'b0;
          if (prev_v_q && next_v_q && next_idx_q == prev_idx_q) next_v_q <= 1'b0;
        end
        OP_FREE_NEXT: next_v_q <= 1'b0;
        OP_MOVE: cnt_q <= cnt_m1;
        OP_APPEND: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        req_q <= in_req_i;
        al_q  <= (in_req_i.alignment == '0) ? AlignW'(1) : in_req_i.alignment;
      end
      OP_FREE_CHK: begin
        if (hit_prev) begin
          prev_idx_q <= idx_q[IdxW-1:0];
          prev_s_q   <= seg_s;
          prev_l_q   <= seg_l;
        end
        if (hit_next) begin
          next_idx_q <= idx_q[IdxW-1:0];
          next_l_q   <= seg_l;
        end
      end
      OP_ALIGN: begin
        aligned_q <= {1'b0, seg_s} +
                     ((rem != '0) ? {{(DataW-AlignW+1){1'b0}}, al_q - rem} : '0);
        end_q     <= seg_end;
      end
      OP_FIT: begin
        hit_q <= idx_q[IdxW-1:0];
        gap_q <= AlignW'(aligned_q - {1'b0, seg_s});
      end
      OP_NEWLEN: newlen_q <= seg_l - req_q.request_size - {{(DataW-AlignW){1'b0}}, gap_q};
      OP_HIT_WR: begin
        app_s_q  <= seg_s;
        app_l_q  <= {{(DataW-AlignW){1'b0}}, gap_q};
        rm_idx_q <= hit_q;
      end
      OP_FREE_DEC: begin
        app_s_q  <= prev_v_q ? prev_s_q : req_q.request_start;
        app_l_q  <= req_q.request_size + (prev_v_q ? prev_l_q : '0);
        rm_idx_q <= prev_idx_q;
        // following neighbor was last: it moves into the preceding slot
        if (prev_v_q && next_v_q && next_idx_q == cnt_m1[IdxW-1:0]) next_idx_q <= prev_idx_q;
      end
      OP_FREE_NEXT: begin
        app_l_q  <= app_l_q + next_l_q;
        rm_idx_q <= next_idx_q;
      end
      OP_RESULT: begin
        rsp_q.status <= cmd_i.status;
        if (cmd_i.status == StatOk && req_q.mode == ModeAlloc) begin
          rsp_q.granted_start <= aligned_q[DataW-1:0];
          rsp_q.granted_size  <= req_q.request_size;
        end else begin
          rsp_q.granted_start <= '0;
          rsp_q.granted_size  <= '0;
        end
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    stat_o.init_pend    = init_q;
    stat_o.mode         = req_q.mode;
    stat_o.count_zero   = (cnt_q == '0);
    stat_o.too_big      = (req_q.request_size > buf_q);
    stat_o.scan_end     = (idx_q >= cnt_q);
    stat_o.len_lt_align = (seg_l < {{(DataW-AlignW){1'b0}}, al_q});
    stat_o.div_done     = div_done;
    stat_o.fit          = ((end_q - aligned_q) >= {1'b0, req_q.request_size});
    stat_o.newlen_zero  = (newlen_q == '0);
    stat_o.gap_zero     = (gap_q == '0);
    stat_o.full         = (cnt_q >= CntW'(MaxSegments));
    stat_o.prev_v       = prev_v_q;
    stat_o.next_v       = next_v_q;
    stat_o.out_free     = !ov_q || out_ready_i;
  end

  assign buf_size_o  = buf_q;
  assign out_valid_o = ov_q;
  assign out_rsp_o   = rsp_q;

  `FFAS_ASSERT(a_count_bound, cnt_q <= CntW'(MaxSegments))
  `FFAS_ASSERT_IMPL(a_append_room, cmd_i.op == OP_APPEND, cnt_q < CntW'(MaxSegments))
  `FFAS_ASSERT_IMPL(a_move_nonempty, cmd_i.op == OP_MOVE, cnt_q != '0)
  `FFAS_ASSERT_IMPL(a_result_slot, cmd_i.op == OP_RESULT, !ov_q || out_ready_i)
endmodule
`default_nettype wire

// ===== rtl/ffas_ctrl.sv =====
// Controller state machine sequencing scans, merges and table updates.
// Depends on ffas_pkg.
`default_nettype none
module ffas_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ffas_pkg::dp_stat_t stat_i,
  output ffas_pkg::dp_cmd_t      cmd_o
);
  import ffas_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= StatOk;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    cmd_o.op     = OP_NONE;
    cmd_o.status = res_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.init_pend) begin
          cmd_o.op = OP_INIT;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.op = OP_LOAD;
            state_d  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        priority if (stat_i.mode != ModeAlloc) begin
          state_d = ST_RD;
        end else if (stat_i.count_zero) begin
          res_d = StatNoSpace; state_d = ST_RESULT;
        end else if (stat_i.too_big) begin
          res_d = StatTooBig; state_d = ST_RESULT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (stat_i.scan_end) begin
          if (stat_i.mode != ModeAlloc) begin
            state_d = ST_F_DEC;
          end else begin
            res_d = StatNoSpace; state_d = ST_RESULT;
          end
        end else begin
          cmd_o.op = OP_READ_I;
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (stat_i.mode != ModeAlloc) begin
          cmd_o.op = OP_FREE_CHK; state_d = ST_RD;
        end else if (stat_i.len_lt_align) begin
          cmd_o.op = OP_SKIP; state_d = ST_RD;
        end else begin
          cmd_o.op = OP_DIV_START; state_d = ST_DIV;
        end
      end
      ST_DIV: if (stat_i.div_done) state_d = ST_ALIGN;
      ST_ALIGN: begin
        cmd_o.op = OP_ALIGN; state_d = ST_FIT;
      end
      ST_FIT: begin
        if (stat_i.fit) begin
          cmd_o.op = OP_FIT; state_d = ST_NEWLEN;
        end else begin
          cmd_o.op = OP_SKIP; state_d = ST_RD;
        end
      end
      ST_NEWLEN: begin
        cmd_o.op = OP_NEWLEN; state_d = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        priority if (!stat_i.newlen_zero && !stat_i.gap_zero && stat_i.full) begin
          res_d = StatFull; state_d = ST_RESULT;
        end else begin
          cmd_o.op = OP_HIT_WR;
          res_d    = StatOk;
          priority if (stat_i.newlen_zero) state_d = ST_RM_RD;
          else if (stat_i.gap_zero) state_d = ST_RESULT;
          else state_d = ST_APPEND;
        end
      end
      ST_F_DEC: begin
        if (!stat_i.prev_v && !stat_i.next_v && stat_i.full) begin
          res_d = StatFull; state_d = ST_RESULT;
        end else begin
          cmd_o.op = OP_FREE_DEC;
          res_d    = StatOk;
          state_d  = stat_i.prev_v ? ST_RM_RD : ST_F_NEXT;
        end
      end
      ST_F_NEXT: begin
        if (stat_i.next_v) begin
          cmd_o.op = OP_FREE_NEXT; state_d = ST_RM_RD;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_RM_RD: begin
        cmd_o.op = OP_READ_LAST; state_d = ST_RM_WR;
      end
      ST_RM_WR: begin
        cmd_o.op = OP_MOVE;
        priority if (stat_i.mode != ModeAlloc) state_d = ST_F_NEXT;
        else if (stat_i.gap_zero) state_d = ST_RESULT;
        else state_d = ST_APPEND;
      end
      ST_APPEND: begin
        cmd_o.op = OP_APPEND; state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RESULT; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/first_fit_aligned_segment_allocator.sv =====
// First-fit aligned segment allocator.
// Request channel (in_valid_i/in_ready_o/in_req_i) takes one allocate or free
// request at a time; the response channel (out_valid_o/out_ready_i/out_rsp_o)
// returns exactly one response per request from an output register.
// An allocate refused up front goes from acceptance straight to its response.
// The scan skips an entry shorter than the alignment after reading it and runs
// every other entry through the bit-serial remainder unit, so the time for an
// allocate or a free grows with count, the number of free-table entries (at
// most 64).
// The next request is accepted once the controller is back in idle, which it
// reaches as the response is loaded into the output register, even while that
// response waits, so requests are handled one at a time.
// If the receiver stalls, the finished response holds and the block waits at
// its end for the output slot to empty.
// Reset sets the buffer length to 65536 and then writes the single free
// segment; writing buffer_size over the APB port does the same.
// Depends on ffas_pkg, ffas_ctrl and ffas_dp.
`default_nettype none
module first_fit_aligned_segment_allocator #(
  parameter int unsigned MaxSegments = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ffas_pkg::req_t             in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ffas_pkg::rsp_t                  out_rsp_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [1:0]                 paddr,
  input  wire logic [ffas_pkg::DataW-1:0] pwdata,
  output logic      [ffas_pkg::DataW-1:0] prdata,
  output logic                            pready
);
  import ffas_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [DataW-1:0] buf_size;

  // register port: single register
  assign pready = 1'b1;
  assign prdata = (paddr == AddrBufferSize) ? buf_size : '0;

  ffas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ffas_dp #(.MaxSegments(MaxSegments)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_req_i   (in_req_i),
    .cfg_we_i   (psel && penable && pwrite && pready),
    .cfg_wdata_i(pwdata),
    .buf_size_o (buf_size),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );
endmodule
`default_nettype wire

// ===== bench/tb_first_fit_aligned_segment_allocator.sv =====
// Testbench for the first-fit aligned segment allocator: random and directed requests,
// responses checked against a behavioral free-table model kept in this file.
// Depends on ffas_pkg and first_fit_aligned_segment_allocator.
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_aligned_segment_allocator;
  import ffas_pkg::*;

  localparam int MaxSeg = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  first_fit_aligned_segment_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i, .out_valid_o, .out_ready_i,
    .out_rsp_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Allocator model state
  logic [31:0] buf_len;
  logic [31:0] free_start [MaxSeg];
  logic [31:0] free_len [MaxSeg];
  int unsigned free_cnt;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int mismatches = 0;
  bit timed_out = 0;
  int hold_off = 0;

  // Handshake bookkeeping
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int unsigned drv_wait = 0;
  int unsigned rcv_wait = 0;
  int unsigned n_accepted = 0;
  rsp_t last_pred = '0;

  // Live segments kept by the bench for well-formed frees
  logic [31:0] owned_start [$];
  logic [31:0] owned_len [$];

  function automatic void enqueue(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void table_init(logic [31:0] len);
    buf_len = len;
    for (int i = 0; i < MaxSeg; i++) begin
      free_start[i] = '0;
      free_len[i] = '0;
    end
    free_len[0] = len;
    free_cnt = 1;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    free_cnt--;
    free_start[idx] = free_start[free_cnt];
    free_len[idx] = free_len[free_cnt];
  endfunction

  function automatic void add_entry(logic [63:0] s, logic [63:0] l);
    if (free_cnt >= MaxSeg) return;
    free_start[free_cnt] = s[31:0];
    free_len[free_cnt] = l[31:0];
    free_cnt++;
  endfunction

  function automatic rsp_t allocator_predict(req_t r);
    rsp_t o;
    logic [63:0] size, algn, s, l, rem, a, gap, nl, st, e, fend;
    int hit, prv, nxt;
    int unsigned last;
    o = '0;
    if (r.mode == ModeAlloc) begin
      size = 64'(r.request_size);
      algn = 64'(r.alignment);
      if (algn == 0) algn = 1;
      if (free_cnt == 0) begin
        o.status = StatNoSpace;
        return o;
      end
      if (size > 64'(buf_len)) begin
        o.status = StatTooBig;
        return o;
      end
      hit = -1;
      for (int i = 0; i < free_cnt; i++) begin
        s = 64'(free_start[i]);
        l = 64'(free_len[i]);
        if (l < algn) continue;
        rem = s % algn;
        a = (rem != 0) ? s + (algn - rem) : s;
        if (s + l - a >= size) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        o.status = StatNoSpace;
        return o;
      end
      s = 64'(free_start[hit]);
      l = 64'(free_len[hit]);
      gap = a - s;
      nl = l - (size + gap);
      if (nl != 0 && gap > 0 && free_cnt >= MaxSeg) begin
        o.status = StatFull;
        return o;
      end
      free_start[hit] = 32'(a + size);
      free_len[hit] = nl[31:0];
      if (nl == 0) drop_entry(hit);
      if (gap > 0) add_entry(s, gap);
      o.status = StatOk;
      o.granted_start = a[31:0];
      o.granted_size = r.request_size;
    end else begin
      st = 64'(r.request_start);
      size = 64'(r.request_size);
      fend = st + size;
      prv = -1;
      nxt = -1;
      for (int i = 0; i < free_cnt; i++) begin
        e = 64'(free_start[i]) + 64'(free_len[i]);
        if (fend == 64'(free_start[i])) nxt = i;
        if (e == st) prv = i;
      end
      if (prv < 0 && nxt < 0 && free_cnt >= MaxSeg) begin
        o.status = StatFull;
        return o;
      end
      if (prv >= 0 && nxt == prv) nxt = -1;
      if (prv >= 0) begin
        last = free_cnt - 1;
        st = 64'(free_start[prv]);
        size += 64'(free_len[prv]);
        drop_entry(prv);
        // the following neighbor may have been moved into the removed slot
        if (nxt >= 0 && nxt == last) nxt = prv;
      end
      if (nxt >= 0) begin
        size += 64'(free_len[nxt]);
        drop_entry(nxt);
      end
      add_entry(st, size);
      o.status = StatOk;
    end
    return o;
  endfunction

  // Driver: presents the next pending request after a random idle gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (drv_wait != 0) begin
        in_valid_i <= 1'b0;
        drv_wait <= drv_wait - 1;
      end else if (pending_reqs.size() != 0) begin
        in_req_i <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        drv_wait <= $urandom_range(0, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Request side: predict each response in acceptance order
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      last_pred = allocator_predict(in_req_i);
      expected_rsps = {expected_rsps, last_pred};
      n_accepted++;
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // Receiver: random stall per response, plus one long hold-off
  always @(negedge clk_i) begin
    int unsigned w;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (out_fire) begin
      w = $urandom_range(0, 11);
      rcv_wait <= (w == 0) ? 0 : w - 1;
      out_ready_i <= (w == 0);
    end else if (rcv_wait != 0) begin
      rcv_wait <= rcv_wait - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: compare each accepted response with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    out_fire <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", out_rsp_o);
      end else begin
        want = expected_rsps.pop_front();
        if (want.status !== out_rsp_o.status || want.granted_start !== out_rsp_o.granted_start
            || want.granted_size !== out_rsp_o.granted_size) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: exp st=%0d start=%h size=%h got st=%0d start=%h size=%h",
                     want.status, want.granted_start, want.granted_size, out_rsp_o.status,
                     out_rsp_o.granted_start, out_rsp_o.granted_size);
        end
      end
    end
  end

  task automatic apb_write_size(logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrBufferSize;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    table_init(v);
    owned_start.delete();
    owned_len.delete();
    repeat (4) @(negedge clk_i);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
           && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  function automatic req_t mk(logic m, logic [31:0] st, logic [31:0] sz, logic [16:0] al);
    req_t r;
    r.mode = m;
    r.request_start = st;
    r.request_size = sz;
    r.alignment = al;
    return r;
  endfunction

  // Mostly well-formed traffic: allocations remembered, then freed in random order, plus some random requests
  task automatic fill_phase(int n, logic [31:0] max_sz);
    req_t r;
    int k;
    int unsigned target;
    logic [16:0] al;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 5 || owned_start.size() == 0) begin
        al = (k == 0) ? 17'($urandom_range(0, 131071)) : 17'(1 << $urandom_range(0, 8));
        if (k == 1) al = 17'($urandom_range(1, 100));
        r = mk(ModeAlloc, $urandom, $urandom_range(0, max_sz), al);
      end else if (k < 9) begin
        k = $urandom_range(0, owned_start.size() - 1);
        r = mk(ModeFree, owned_start[k], owned_len[k], 17'($urandom));
        owned_start.delete(k);
        owned_len.delete(k);
      end else begin
        r = mk(1'($urandom), $urandom, $urandom, 17'($urandom));
      end
      target = n_accepted + 1;
      enqueue(r);
      // track grants by waiting for this request to be accepted
      while (n_accepted != target) @(posedge clk_i);
      if (r.mode == ModeAlloc && last_pred.status == StatOk && last_pred.granted_size != 0) begin
        owned_start = {owned_start, last_pred.granted_start};
        owned_len = {owned_len, last_pred.granted_size};
      end
    end
  endtask

  initial begin
    table_init(BufSizeReset);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // Directed: extremes, too big, zero size, zero alignment, odd alignment
    enqueue(mk(ModeAlloc, '1, 32'd65537, 17'd1));
    enqueue(mk(ModeAlloc, 0, 32'd0, 17'd0));
    enqueue(mk(ModeAlloc, 0, 32'd100, 17'd3));
    enqueue(mk(ModeAlloc, 0, 32'd7, 17'h10000));
    enqueue(mk(ModeAlloc, 0, 32'd1, 17'h1FFFF));
    enqueue(mk(ModeFree, 32'd102, 32'd5, 17'd0));
    enqueue(mk(ModeFree, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 17'h1FFFF));
    enqueue(mk(ModeAlloc, 0, 32'd65536, 17'd1));
    drain();

    apb_write_size(32'd0);
    enqueue(mk(ModeAlloc, 0, 32'd0, 17'd1));
    enqueue(mk(ModeAlloc, 0, 32'd1, 17'd1));
    enqueue(mk(ModeFree, 0, 32'd0, 17'd1));
    drain();

    apb_write_size(32'hFFFF_FFFF);
    enqueue(mk(ModeAlloc, 0, 32'hFFFF_FFFF, 17'd2));
    enqueue(mk(ModeAlloc, 0, 32'h8000_0000, 17'h10000));
    enqueue(mk(ModeFree, 32'h1_0000, 32'h8000_0000, 17'd1));
    drain();

    // Many small aligned slivers to fill the table
    apb_write_size(32'd4096);
    for (int i = 0; i < 70; i++) enqueue(mk(ModeAlloc, 0, 32'd1, 17'd48));
    hold_off = 400;
    for (int i = 0; i < 40; i++)
      enqueue(mk(ModeFree, $urandom_range(0, 4200), $urandom_range(0, 60), 17'd1));
    drain();

    apb_write_size(32'd1);
    fill_phase(60, 32'd2);
    drain();
    apb_write_size(32'd2000);
    fill_phase(450, 32'd300);
    drain();
    apb_write_size(BufSizeReset);
    fill_phase(450, 32'd9000);
    drain();

    if (mismatches == 0 && expected_rsps.size() == 0 && !timed_out) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    timed_out = 1;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
